// ----- hdl/spds_pkg.sv -----
// Shared types and constants for the stochastic particle drift step unit.
// Holds the channel payload structs, register indexes, controller commands,
// the CORDIC arctangent table and the saturation helper. No dependencies.
package spds_pkg;

    // Register indexes of the configuration port
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ANGLE_GAIN   = 3'd0,
        CFG_DRIFT        = 3'd1,
        CFG_SPREAD       = 3'd2,
        CFG_DECAY        = 3'd3,
        CFG_CENTER_X     = 3'd4,
        CFG_CENTER_Y     = 3'd5,
        CFG_INITIAL_BURN = 3'd6
    } t_cfg_idx;

    // Item modes
    localparam logic MODE_RESTART = 1'b0;
    localparam logic MODE_ADVANCE = 1'b1;

    // CORDIC constants
    localparam int ATAN_LEN = 24;
    localparam int STEP_W = 5;
    localparam int ATAN_W = 31;
    localparam int CX_W = 33;
    localparam int CZ_W = 34;
    localparam logic signed [CX_W-1:0] CORDIC_INIT = 33'sd652032874;

    typedef struct packed {
        logic               mode;
        logic signed [15:0] noise_angle;
        logic signed [15:0] noise_radius;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic [19:0]        burn_level;
    } t_out_item;

    // Operand selection of the shared multiplier
    typedef enum logic [2:0] {
        MUL_HEAD,
        MUL_RAD,
        MUL_PX,
        MUL_PY,
        MUL_BURN
    } t_mul_sel;

    typedef struct packed {
        logic              capture;
        logic              restart;
        t_mul_sel          mul_sel;
        logic              upd_heading;
        logic              upd_radius;
        logic              cordic_init;
        logic              cordic_step;
        logic [STEP_W-1:0] step_idx;
        logic              place_x;
        logic              place_y;
        logic              upd_burn;
        logic              load_out;
    } t_dp_cmd;

    // Arctangent of 2^-i in 2^32 per turn
    function automatic logic [ATAN_W-1:0] atan_entry(input logic [STEP_W-1:0] idx);
        logic [ATAN_W-1:0] v;
        case (idx)
            5'd0:    v = 31'd536870912;
            5'd1:    v = 31'd316933406;
            5'd2:    v = 31'd167458907;
            5'd3:    v = 31'd85004756;
            5'd4:    v = 31'd42667331;
            5'd5:    v = 31'd21354465;
            5'd6:    v = 31'd10679838;
            5'd7:    v = 31'd5340245;
            5'd8:    v = 31'd2670163;
            5'd9:    v = 31'd1335087;
            5'd10:   v = 31'd667544;
            5'd11:   v = 31'd333772;
            5'd12:   v = 31'd166886;
            5'd13:   v = 31'd83443;
            5'd14:   v = 31'd41722;
            5'd15:   v = 31'd20861;
            5'd16:   v = 31'd10430;
            5'd17:   v = 31'd5215;
            5'd18:   v = 31'd2608;
            5'd19:   v = 31'd1304;
            5'd20:   v = 31'd652;
            5'd21:   v = 31'd326;
            5'd22:   v = 31'd163;
            5'd23:   v = 31'd81;
            default: v = 31'd0;
        endcase
        return v;
    endfunction

    // Clamp to the 32 bit signed range
    function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
        logic signed [31:0] r;
        if (v > 40'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -40'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ----- hdl/stochastic_particle_drift_step_unit.sv -----
// Top level of the stochastic particle drift step unit.
// Joins the controller (spds_ctrl) and the datapath (spds_dp); uses spds_pkg.
//
//  channel | direction | handshake                    | payload
//  --------+-----------+------------------------------+-------------------------------
//  in      | input     | i_in_valid / o_in_ready      | i_in_data  (t_in_item)
//  out     | output    | o_out_valid / i_out_ready    | o_out_data (t_out_item)
//  cfg     | input     | i_cfg_we, no wait            | i_cfg_idx, i_cfg_data
//
// An advance item runs the CORDIC rotation loop, which runs one step a cycle,
// and five products that share one 32x32 multiplier, then loads its result.
// A restart item goes straight to the load. The controller returns to idle
// after each load, so a new item is taken only once the last one is loaded.
// Reset is synchronous, active low, and needs no clearing pass. A new item is
// taken while a result waits in the output register; a stalled output holds
// the controller in its final state.
module stochastic_particle_drift_step_unit #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  spds_pkg::t_in_item              i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output spds_pkg::t_out_item             o_out_data,
    input  logic                            i_cfg_we,
    input  logic [spds_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [spds_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import spds_pkg::*;

    // Command bundle from the controller to the datapath
    t_dp_cmd w_cmd;

    // Sequence each transfer: capture noise; for an advance, update heading and radius,
    // rotate, place, decay; then load the output register.
    spds_ctrl #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_mode     (i_in_data.mode),
        .o_in_ready (o_in_ready),
        .i_out_ready(i_out_ready),
        .o_out_valid(o_out_valid),
        .o_cmd      (w_cmd)
    );

    // Hold configuration and particle state; do the arithmetic.
    spds_dp u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .i_in_data (i_in_data),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .o_out_data(o_out_data)
    );

endmodule

// ----- hdl/spds_ctrl.sv -----
// Controller state machine of the particle drift step unit.
// Sequences the shared multiplier, the CORDIC iterations and the output register.
// Depends on spds_pkg.
module spds_ctrl #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_mode,
    output logic              o_in_ready,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output spds_pkg::t_dp_cmd o_cmd
);
    import spds_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_H,
        S_MUL_R,
        S_RAD,
        S_CORD,
        S_MUL_X,
        S_MUL_Y,
        S_MUL_B,
        S_BURN,
        S_OUT
    } t_state;

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_out_valid, n_out_valid;
    logic              w_accept;
    logic              w_slot_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign w_accept    = i_in_valid && (r_state == S_IDLE);
    assign w_slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_cmd.mul_sel  = MUL_HEAD;
        o_cmd.step_idx = r_step;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.capture = 1'b1;
                    if (i_mode == MODE_RESTART) begin
                        o_cmd.restart = 1'b1;
                        n_state = S_OUT;
                    end else begin
                        n_state = S_MUL_H;
                    end
                end
            end
            S_MUL_H: begin
                o_cmd.mul_sel = MUL_HEAD;
                n_state = S_MUL_R;
            end
            S_MUL_R: begin
                o_cmd.upd_heading = 1'b1;
                o_cmd.mul_sel     = MUL_RAD;
                n_state = S_RAD;
            end
            S_RAD: begin
                o_cmd.upd_radius  = 1'b1;
                o_cmd.cordic_init = 1'b1;
                n_step  = '0;
                n_state = S_CORD;
            end
            S_CORD: begin
                o_cmd.cordic_step = 1'b1;
                if (r_step == LAST_STEP) begin
                    n_state = S_MUL_X;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_MUL_X: begin
                o_cmd.mul_sel = MUL_PX;
                n_state = S_MUL_Y;
            end
            S_MUL_Y: begin
                o_cmd.place_x = 1'b1;
                o_cmd.mul_sel = MUL_PY;
                n_state = S_MUL_B;
            end
            S_MUL_B: begin
                o_cmd.place_y = 1'b1;
                o_cmd.mul_sel = MUL_BURN;
                n_state = S_BURN;
            end
            S_BURN: begin
                o_cmd.upd_burn = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                // hold until the output register is empty or being taken
                if (w_slot_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ----- hdl/spds_dp.sv -----
// Datapath of the particle drift step unit: configuration registers, particle
// state, shared 32x32 multiplier, iterative CORDIC and the output register.
// Depends on spds_pkg; driven by commands from spds_ctrl.
module spds_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  spds_pkg::t_dp_cmd                  i_cmd,
    input  spds_pkg::t_in_item                 i_in_data,
    input  logic                               i_cfg_we,
    input  logic [spds_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [spds_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output spds_pkg::t_out_item                o_out_data
);
    import spds_pkg::*;

    // Configuration registers
    logic [15:0]        r_angle_gain;
    logic signed [31:0] r_drift;
    logic [30:0]        r_spread;
    logic [15:0]        r_decay;
    logic signed [31:0] r_center_x;
    logic signed [31:0] r_center_y;
    logic [19:0]        r_initial_burn;

    // Particle state
    logic [15:0]        r_heading;
    logic signed [31:0] r_radius;
    logic [19:0]        r_burn;

    logic signed [15:0] r_noise_a;
    logic signed [15:0] r_noise_r;
    logic signed [63:0] r_prod;
    logic signed [CX_W-1:0] r_cx, r_cy;
    logic signed [CZ_W-1:0] r_cz;
    logic               r_flip;
    logic signed [31:0] r_res_x, r_res_y;
    t_out_item          r_out;

    logic signed [31:0] w_mul_a, w_mul_b;
    logic [27:0]        w_head_sum;
    logic signed [46:0] w_rt_sum;
    logic signed [34:0] w_rt;
    logic signed [39:0] w_rad_sum;
    logic [31:0]        w_ang;
    logic               w_flip;
    logic signed [31:0] w_ang_f;
    logic signed [CX_W-1:0] w_dx, w_dy, w_cx_f, w_cy_f;
    logic signed [CZ_W-1:0] w_atan;
    logic signed [31:0] w_cos, w_sin;
    logic signed [63:0] w_pl_sum;
    logic signed [33:0] w_pl;
    logic signed [31:0] w_place_x, w_place_y;
    logic [35:0]        w_burn_sum;
    logic [19:0]        w_dec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle_gain   <= 16'd16384;
            r_drift        <= '0;
            r_spread       <= '0;
            r_decay        <= '0;
            r_center_x     <= '0;
            r_center_y     <= '0;
            r_initial_burn <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_ANGLE_GAIN:   r_angle_gain   <= i_cfg_data[15:0];
                CFG_DRIFT:        r_drift        <= i_cfg_data;
                CFG_SPREAD:       r_spread       <= i_cfg_data[30:0];
                CFG_DECAY:        r_decay        <= i_cfg_data[15:0];
                CFG_CENTER_X:     r_center_x     <= i_cfg_data;
                CFG_CENTER_Y:     r_center_y     <= i_cfg_data;
                CFG_INITIAL_BURN: r_initial_burn <= i_cfg_data[19:0];
                default: ;
            endcase
        end
    end

    // Shared multiplier operands
    always_comb begin
        case (i_cmd.mul_sel)
            MUL_HEAD: begin
                w_mul_a = $signed({16'd0, r_angle_gain});
                w_mul_b = 32'(r_noise_a);
            end
            MUL_RAD: begin
                w_mul_a = $signed({1'b0, r_spread});
                w_mul_b = 32'(r_noise_r);
            end
            MUL_PX: begin
                w_mul_a = r_radius;
                w_mul_b = w_cos;
            end
            MUL_PY: begin
                w_mul_a = r_radius;
                w_mul_b = w_sin;
            end
            MUL_BURN: begin
                w_mul_a = $signed({12'd0, r_burn});
                w_mul_b = $signed({16'd0, r_decay});
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    // Heading: round Q3.28 to Q0.16, wrap
    assign w_head_sum = r_prod[27:0] + 28'd2048;

    // Radius: round the spread term, add drift, saturate
    assign w_rt_sum  = r_prod[46:0] + 47'sd2048;
    assign w_rt      = w_rt_sum[46:12];
    assign w_rad_sum = 40'(r_radius) + 40'(r_drift) + 40'(w_rt);

    // CORDIC setup: fold second and third quadrant by half a turn
    assign w_ang   = {r_heading, 16'd0};
    assign w_flip  = w_ang[31] ^ w_ang[30];
    assign w_ang_f = {w_ang[31] ^ w_flip, w_ang[30:0]};

    assign w_dx   = r_cy >>> i_cmd.step_idx;
    assign w_dy   = r_cx >>> i_cmd.step_idx;
    assign w_atan = $signed({3'd0, atan_entry(i_cmd.step_idx)});

    assign w_cx_f = r_flip ? -r_cx : r_cx;
    assign w_cy_f = r_flip ? -r_cy : r_cy;
    assign w_cos  = w_cx_f[31:0];
    assign w_sin  = w_cy_f[31:0];

    // Placement: round Q.30 product, add center, saturate
    assign w_pl_sum  = r_prod + 64'sd536870912;
    assign w_pl      = w_pl_sum[63:30];
    assign w_place_x = sat32(40'(r_center_x) + 40'(w_pl));
    assign w_place_y = sat32(40'(r_center_y) + 40'(w_pl));

    // Burn decay, rounded
    assign w_burn_sum = r_prod[35:0] + 36'd32768;
    assign w_dec      = w_burn_sum[35:16];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heading <= '0;
            r_radius  <= '0;
            r_burn    <= '0;
        end else if (i_cmd.restart) begin
            r_heading <= '0;
            r_radius  <= '0;
            r_burn    <= r_initial_burn;
        end else begin
            if (i_cmd.upd_heading) begin
                r_heading <= r_heading + w_head_sum[27:12];
            end
            if (i_cmd.upd_radius) begin
                r_radius <= sat32(w_rad_sum);
            end
            if (i_cmd.upd_burn) begin
                r_burn <= r_burn - w_dec;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= 64'(w_mul_a) * 64'(w_mul_b);
        if (i_cmd.capture) begin
            r_noise_a <= i_in_data.noise_angle;
            r_noise_r <= i_in_data.noise_radius;
        end
        if (i_cmd.cordic_init) begin
            r_cx   <= CORDIC_INIT;
            r_cy   <= '0;
            r_cz   <= CZ_W'(w_ang_f);
            r_flip <= w_flip;
        end else if (i_cmd.cordic_step) begin
            if (!r_cz[CZ_W-1]) begin
                r_cx <= r_cx - w_dx;
                r_cy <= r_cy + w_dy;
                r_cz <= r_cz - w_atan;
            end else begin
                r_cx <= r_cx + w_dx;
                r_cy <= r_cy - w_dy;
                r_cz <= r_cz + w_atan;
            end
        end
        if (i_cmd.restart) begin
            r_res_x <= r_center_x;
            r_res_y <= r_center_y;
        end else begin
            if (i_cmd.place_x) begin
                r_res_x <= w_place_x;
            end
            if (i_cmd.place_y) begin
                r_res_y <= w_place_y;
            end
        end
        if (i_cmd.load_out) begin
            r_out.pos_x      <= r_res_x;
            r_out.pos_y      <= r_res_y;
            r_out.burn_level <= r_burn;
        end
    end

    assign o_out_data = r_out;

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for stochastic_particle_drift_step_unit.
// Drives random and directed particle steps through the valid/ready channels, predicts
// every result with its own fixed-point model, and needs only hdl/spds_pkg.sv and the RTL.
`timescale 1ns / 100ps

module testbench;

    import spds_pkg::*;

    localparam int      ROTATION_STEPS = 16;
    localparam int      CYCLE_LIMIT    = 500000;
    localparam int      DRAIN_CYCLES   = 40;
    localparam int      LONG_HOLD      = 300;
    localparam int      RANDOM_PHASES  = 8;
    localparam int      PHASE_ITEMS    = 130;
    // no register sits at this index, writes to it must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 3'd7;

    logic                  i_clk      = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  in_valid   = 1'b0;
    t_in_item              in_data    = '0;
    logic                  out_ready  = 1'b0;
    logic                  cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx    = '0;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;
    logic                  o_in_ready;
    logic                  o_out_valid;
    t_out_item             o_out_data;

    stochastic_particle_drift_step_unit #(
        .CORDIC_STEPS (ROTATION_STEPS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Arctangent of 2^-i, in 2^32 per turn
    longint atan_turn_steps [0:23] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };

    // Register copies, kept in sync with every write on the port
    longint gain_r, drift_r, spread_r, decay_r, cx_r, cy_r, burn_init_r;
    // Particle state
    logic [15:0] heading_q;
    longint      radius_q;
    longint      burn_q;

    t_in_item  stimulus_q [$];
    t_out_item predicted_steps [$];

    int  cycle_count     = 0;
    int  mismatch_count  = 0;
    int  items_accepted  = 0;
    int  results_checked = 0;
    int  restarts_queued = 0;
    int  settings_used   = 0;
    int  send_gap        = 0;
    int  hold_left       = 0;
    bit  in_fired        = 1'b0;
    bit  calm            = 1'b0;
    bit  long_hold_go    = 1'b0;
    bit  long_hold_done  = 1'b0;

    function automatic longint clamp_q31(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Advance the particle state by one item and return the position it yields
    function automatic t_out_item drift_step_predict(input t_in_item it);
        t_out_item  r;
        longint     na, nr, dh, x, y, z, dx, dy, px, py, dec;
        logic [31:0] a;
        bit         flip;
        if (it.mode == MODE_RESTART) begin
            heading_q = '0;
            radius_q  = 0;
            burn_q    = burn_init_r;
            px = cx_r;
            py = cy_r;
        end else begin
            na = longint'($signed(it.noise_angle));
            nr = longint'($signed(it.noise_radius));
            dh = (gain_r * na + 64'sd2048) >>> 12;
            heading_q = 16'(longint'(heading_q) + dh);
            radius_q  = clamp_q31(radius_q + drift_r + ((spread_r * nr + 64'sd2048) >>> 12));
            // fold the second and third quadrant onto the first and fourth
            a    = {heading_q, 16'h0000};
            flip = (a[31:30] == 2'b01) || (a[31:30] == 2'b10);
            if (flip) a[31] = ~a[31];
            z = longint'($signed(a));
            x = 652032874;
            y = 0;
            for (int i = 0; i < ROTATION_STEPS && i < 24; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x = x - dx; y = y + dy; z = z - atan_turn_steps[i];
                end else begin
                    x = x + dx; y = y - dy; z = z + atan_turn_steps[i];
                end
            end
            if (flip) begin
                x = -x;
                y = -y;
            end
            px  = clamp_q31(cx_r + ((radius_q * x + 64'sd536870912) >>> 30));
            py  = clamp_q31(cy_r + ((radius_q * y + 64'sd536870912) >>> 30));
            dec = (burn_q * decay_r + 64'sd32768) >> 16;
            burn_q = (burn_q - dec) & 64'sd1048575;
        end
        r.pos_x      = 32'(px);
        r.pos_y      = 32'(py);
        r.burn_level = 20'(burn_q);
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("mismatch @%0d: %s", cycle_count, msg);
    endtask

    // Sender: offer the next queued item once the current one has transferred
    always @(negedge i_clk) begin
        if (rst_n && (!in_valid || in_fired)) begin
            if (send_gap > 0) begin
                send_gap--;
                in_valid <= 1'b0;
            end else if (stimulus_q.size() != 0 && !calm && $urandom_range(0, 5) == 0) begin
                send_gap = $urandom_range(0, 4);
                in_valid <= 1'b0;
            end else if (stimulus_q.size() != 0) begin
                in_valid <= 1'b1;
                in_data  <= stimulus_q.pop_front();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random short stalls, plus one long hold-off on request
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else if (long_hold_go && !long_hold_done) begin
            long_hold_done = 1'b1;
            hold_left = LONG_HOLD - 1;
            out_ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 4) == 0) begin
            hold_left = $urandom_range(0, 4);
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    // Monitor: check results first, then record the transfer on the input side
    always @(posedge i_clk) begin
        t_out_item want;
        cycle_count++;
        if (rst_n && o_out_valid && out_ready) begin
            if (predicted_steps.size() == 0) begin
                report_mismatch("result with nothing expected");
            end else begin
                want = predicted_steps.pop_front();
                if (o_out_data.pos_x !== want.pos_x)
                    report_mismatch($sformatf("result %0d pos_x got %0d want %0d",
                        results_checked, o_out_data.pos_x, want.pos_x));
                if (o_out_data.pos_y !== want.pos_y)
                    report_mismatch($sformatf("result %0d pos_y got %0d want %0d",
                        results_checked, o_out_data.pos_y, want.pos_y));
                if (o_out_data.burn_level !== want.burn_level)
                    report_mismatch($sformatf("result %0d burn_level got %0h want %0h",
                        results_checked, o_out_data.burn_level, want.burn_level));
            end
            results_checked++;
        end
        in_fired = rst_n && in_valid && o_in_ready;
        if (in_fired) begin
            predicted_steps.push_back(drift_step_predict(in_data));
            items_accepted++;
        end
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                cycle_count, predicted_steps.size());
            $display("[stochastic_particle_drift_step_unit] ERROR");
            $finish;
        end
    end

    // Write one register and mirror it in the model
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        case (idx)
            CFG_ANGLE_GAIN:   gain_r      = longint'(data[15:0]);
            CFG_DRIFT:        drift_r     = longint'($signed(data));
            CFG_SPREAD:       spread_r    = longint'(data[30:0]);
            CFG_DECAY:        decay_r     = longint'(data[15:0]);
            CFG_CENTER_X:     cx_r        = longint'($signed(data));
            CFG_CENTER_Y:     cy_r        = longint'($signed(data));
            CFG_INITIAL_BURN: burn_init_r = longint'(data[19:0]);
            default: ;
        endcase
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic write_all(input logic [31:0] gain, input logic [31:0] drift,
                             input logic [31:0] spread, input logic [31:0] decay,
                             input logic [31:0] cx, input logic [31:0] cy,
                             input logic [31:0] burn);
        write_reg(CFG_ANGLE_GAIN, gain);
        write_reg(CFG_DRIFT, drift);
        write_reg(CFG_SPREAD, spread);
        write_reg(CFG_DECAY, decay);
        write_reg(CFG_CENTER_X, cx);
        write_reg(CFG_CENTER_Y, cy);
        write_reg(CFG_INITIAL_BURN, burn);
        settings_used++;
    endtask

    task automatic queue_item(input logic mode, input logic [15:0] na, input logic [15:0] nr);
        t_in_item it;
        it.mode         = mode;
        it.noise_angle  = na;
        it.noise_radius = nr;
        if (mode == MODE_RESTART) restarts_queued++;
        stimulus_q.push_back(it);
    endtask

    // Hold until every item has transferred and every result has come back
    task automatic wait_drained();
        while (stimulus_q.size() != 0 || in_valid || predicted_steps.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Mostly bell-shaped samples around zero, sometimes raw bits or extremes
    function automatic logic [15:0] noise_sample();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) return 16'($urandom);
        if (pick == 1) begin
            case ($urandom_range(0, 3))
                0:       return 16'h7FFF;
                1:       return 16'h8000;
                2:       return 16'hFFFF;
                default: return 16'h0000;
            endcase
        end
        return 16'($urandom_range(0, 4096) + $urandom_range(0, 4096)
                   + $urandom_range(0, 4096) + $urandom_range(0, 4096)) - 16'd8192;
    endfunction

    function automatic logic [31:0] wide_value();
        case ($urandom_range(0, 7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h7FFF_FFFF;
            3:       return 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        logic [31:0] rv [0:6];
        // model state after reset
        gain_r = 16384; drift_r = 0; spread_r = 0; decay_r = 0;
        cx_r = 0; cy_r = 0; burn_init_r = 0;
        heading_q = '0; radius_q = 0; burn_q = 0;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        rst_n <= 1'b1;
        repeat (4) @(posedge i_clk);

        // Reset settings: radius stays zero, burn stays empty
        settings_used++;
        queue_item(MODE_ADVANCE, 16'h0000, 16'h0000);
        queue_item(MODE_RESTART, 16'h7FFF, 16'h8000);
        queue_item(MODE_ADVANCE, 16'h7FFF, 16'h7FFF);
        wait_drained();

        // Ends of every range, centre y at its bottom: radius and both positions clamp
        write_all(32'h0000_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_FFFF,
                  32'h7FFF_FFFF, 32'h8000_0000, 32'h000F_FFFF);
        write_reg(CFG_IDX_UNUSED, 32'hDEAD_BEEF);
        queue_item(MODE_RESTART, 16'h0000, 16'h0000);
        queue_item(MODE_ADVANCE, 16'h7FFF, 16'h7FFF);
        queue_item(MODE_ADVANCE, 16'h8000, 16'h8000);
        queue_item(MODE_ADVANCE, 16'h7FFF, 16'h8000);
        queue_item(MODE_ADVANCE, 16'h8000, 16'h7FFF);
        queue_item(MODE_ADVANCE, 16'hFFFF, 16'h0001);
        queue_item(MODE_ADVANCE, 16'h0001, 16'hFFFF);
        wait_drained();

        // Most negative drift with a frozen heading: radius clamps low
        write_all(32'h0000_0000, 32'h8000_0000, 32'h0000_0000, 32'h0000_8000,
                  32'h0000_0000, 32'h0000_0000, 32'h0008_0000);
        queue_item(MODE_RESTART, 16'h1234, 16'h4321);
        queue_item(MODE_ADVANCE, 16'h7FFF, 16'h0000);
        queue_item(MODE_ADVANCE, 16'h8000, 16'h0000);
        queue_item(MODE_ADVANCE, 16'h0000, 16'h0000);
        wait_drained();

        // Small negative drift: particle sits on the far side of the centre
        write_all(32'h0000_4000, 32'hFFFF_0000, 32'h0000_8000, 32'h0000_0100,
                  32'h0010_0000, 32'hFFF0_0000, 32'h0001_0000);
        queue_item(MODE_RESTART, 16'h0000, 16'h0000);
        queue_item(MODE_ADVANCE, 16'h1000, 16'h0000);
        queue_item(MODE_ADVANCE, 16'h1000, 16'hF000);
        queue_item(MODE_ADVANCE, 16'h1000, 16'h1000);
        queue_item(MODE_ADVANCE, 16'h1000, 16'h0800);
        queue_item(MODE_ADVANCE, 16'hC000, 16'h0000);
        wait_drained();

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            if (ph % 3 == 1) begin
                for (int k = 0; k < 7; k++) rv[k] = wide_value();
            end else begin
                rv[0] = $urandom_range(0, 65535);
                rv[1] = 32'($urandom_range(0, 262144)) - 32'd131072;
                rv[2] = $urandom_range(0, 262144);
                rv[3] = $urandom_range(0, 2048);
                rv[4] = 32'($urandom_range(0, 16777216)) - 32'd8388608;
                rv[5] = 32'($urandom_range(0, 16777216)) - 32'd8388608;
                rv[6] = $urandom_range(0, 20'hFFFFF);
            end
            write_all(rv[0], rv[1], rv[2], rv[3], rv[4], rv[5], rv[6]);
            if ($urandom_range(0, 2) == 0) write_reg(CFG_IDX_UNUSED, $urandom);

            // fill the block against a long receiver stall in one phase
            if (ph == 2) long_hold_go = 1'b1;
            // no idling on either side in the closing phase
            if (ph == RANDOM_PHASES - 1) calm = 1'b1;

            queue_item(MODE_RESTART, noise_sample(), noise_sample());
            for (int n = 1; n < PHASE_ITEMS; n++) begin
                queue_item(($urandom_range(0, 9) == 0) ? MODE_RESTART : MODE_ADVANCE,
                           noise_sample(), noise_sample());
            end
            wait_drained();
        end

        $display("covered %0d items (%0d restarts) over %0d register settings",
            items_accepted, restarts_queued, settings_used);
        $display("checked %0d results, %0d mismatches", results_checked, mismatch_count);
        if (mismatch_count == 0) begin
            $display("[stochastic_particle_drift_step_unit] OK");
        end else begin
            $display("[stochastic_particle_drift_step_unit] ERROR");
        end
        $finish;
    end

endmodule
